FILE: design/sha256_pkg.sv
`default_nettype none
package sha256_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_LEN,
		ST_COMP,
		ST_OUT
	} state_t;

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LEN_POS  = 6'd56;

	localparam logic [31:0] IV [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] RK [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
		rotr = (v >> n) | (v << (32 - n));
	endfunction

endpackage
`default_nettype wire

FILE: design/sha256_hash_engine.sv
// SHA-256 engine taking one message byte per input word (action 0 absorbs
// data_byte, action 1 pads the message and finishes it). After a finish the
// eight digest words leave on the output channel, most significant first,
// with word_index and last_word marking their place; the engine then starts
// a fresh message. The 64-byte block buffer is a byte shift line that
// doubles as the 16-word message schedule window during compression, and one
// shared round unit does one SHA-256 round per cycle. The byte that completes
// a block starts its compression. A finish shifts in the 0x80 byte, then the
// zero padding and length bytes up to the block end, pausing at byte 56
// ahead of the length bytes in the final block (a first block is padded out
// and compressed when the 0x80 lands past byte 55), then the last block is
// compressed, and eight output words leave at one per cycle while the
// output is not stalled. The input is stalled throughout all of that.
`default_nettype none
module sha256_hash_engine (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        action,
	input  wire logic [7:0]  data_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      digest_word,
	output logic [2:0]       word_index,
	output logic             last_word
);

	sha256_pkg::state_t state_q, state_d, ret_q;

	logic [5:0]   fill_q;
	logic [60:0]  count_q;
	logic [5:0]   rnd_q;
	logic [2:0]   idx_q;
	logic [31:0]  hash_q [8];
	logic [31:0]  v_q [8];
	logic [511:0] buf_q;
	logic [63:0]  bits_q;

	logic in_acc, out_acc;
	logic [31:0] w0, w1, w9, w14, s0, s1, wnew;
	logic [31:0] bs0, bs1, ch, maj, t1, t2;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;

	// schedule window: oldest word at the top of the buffer
	assign w0  = buf_q[511:480];
	assign w1  = buf_q[479:448];
	assign w9  = buf_q[223:192];
	assign w14 = buf_q[63:32];

	always_comb begin
		s0   = sha256_pkg::rotr(w1, 7) ^ sha256_pkg::rotr(w1, 18) ^ (w1 >> 3);
		s1   = sha256_pkg::rotr(w14, 17) ^ sha256_pkg::rotr(w14, 19) ^ (w14 >> 10);
		wnew = w0 + s0 + w9 + s1;
		bs1  = sha256_pkg::rotr(v_q[4], 6) ^ sha256_pkg::rotr(v_q[4], 11)
			^ sha256_pkg::rotr(v_q[4], 25);
		ch   = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		t1   = v_q[7] + bs1 + ch + sha256_pkg::RK[rnd_q] + w0;
		bs0  = sha256_pkg::rotr(v_q[0], 2) ^ sha256_pkg::rotr(v_q[0], 13)
			^ sha256_pkg::rotr(v_q[0], 22);
		maj  = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t2   = bs0 + maj;
	end

	// next state and handshake outputs
	always_comb begin
		state_d     = state_q;
		in_stall    = (state_q != sha256_pkg::ST_IDLE);
		out_valid   = (state_q == sha256_pkg::ST_OUT);
		digest_word = hash_q[idx_q];
		word_index  = idx_q;
		last_word   = (idx_q == 3'd7);
		case (state_q)
			sha256_pkg::ST_IDLE: begin
				if (in_acc) begin
					if (action)
						state_d = (fill_q == 6'd63) ? sha256_pkg::ST_COMP
							: sha256_pkg::ST_PAD;
					else if (fill_q == 6'd63)
						state_d = sha256_pkg::ST_COMP;
				end
			end
			sha256_pkg::ST_PAD: begin
				if (fill_q == sha256_pkg::LEN_POS)
					state_d = sha256_pkg::ST_LEN;
				else if (fill_q == 6'd63)
					state_d = sha256_pkg::ST_COMP;
			end
			sha256_pkg::ST_LEN: begin
				if (fill_q == 6'd63)
					state_d = sha256_pkg::ST_COMP;
			end
			sha256_pkg::ST_COMP: begin
				if (rnd_q == 6'd63)
					state_d = ret_q;
			end
			sha256_pkg::ST_OUT: begin
				if (out_acc && idx_q == 3'd7)
					state_d = sha256_pkg::ST_IDLE;
			end
			default: state_d = sha256_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sha256_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control and hash state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ret_q   <= sha256_pkg::ST_IDLE;
			fill_q  <= '0;
			count_q <= '0;
			rnd_q   <= '0;
			idx_q   <= '0;
			for (int i = 0; i < 8; i++) hash_q[i] <= sha256_pkg::IV[i];
		end else begin
			case (state_q)
				sha256_pkg::ST_IDLE: begin
					rnd_q <= '0;
					if (in_acc) begin
						fill_q <= fill_q + 6'd1;
						if (action) begin
							ret_q <= sha256_pkg::ST_PAD;
						end else begin
							count_q <= count_q + 61'd1;
							ret_q   <= sha256_pkg::ST_IDLE;
						end
					end
				end
				sha256_pkg::ST_PAD: begin
					rnd_q <= '0;
					ret_q <= sha256_pkg::ST_PAD;
					if (fill_q != sha256_pkg::LEN_POS)
						fill_q <= fill_q + 6'd1;
				end
				sha256_pkg::ST_LEN: begin
					rnd_q  <= '0;
					ret_q  <= sha256_pkg::ST_OUT;
					fill_q <= fill_q + 6'd1;
				end
				sha256_pkg::ST_COMP: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) begin
						hash_q[0] <= hash_q[0] + t1 + t2;
						hash_q[1] <= hash_q[1] + v_q[0];
						hash_q[2] <= hash_q[2] + v_q[1];
						hash_q[3] <= hash_q[3] + v_q[2];
						hash_q[4] <= hash_q[4] + v_q[3] + t1;
						hash_q[5] <= hash_q[5] + v_q[4];
						hash_q[6] <= hash_q[6] + v_q[5];
						hash_q[7] <= hash_q[7] + v_q[6];
					end
				end
				sha256_pkg::ST_OUT: begin
					if (out_acc) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == 3'd7) begin
							fill_q  <= '0;
							count_q <= '0;
							for (int i = 0; i < 8; i++) hash_q[i] <= sha256_pkg::IV[i];
						end
					end
				end
				default: ;
			endcase
		end
	end

	// datapath: byte line / schedule window, working variables, length
	always_ff @(posedge clk) begin
		if (state_q == sha256_pkg::ST_COMP) begin
			buf_q <= {buf_q[479:0], wnew};
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end else begin
			for (int i = 0; i < 8; i++) v_q[i] <= hash_q[i];
			case (state_q)
				sha256_pkg::ST_IDLE: begin
					if (in_acc) begin
						bits_q <= {count_q, 3'b000};
						buf_q  <= {buf_q[503:0], action ? sha256_pkg::PAD_BYTE : data_byte};
					end
				end
				sha256_pkg::ST_PAD: begin
					if (fill_q != sha256_pkg::LEN_POS)
						buf_q <= {buf_q[503:0], 8'h00};
				end
				sha256_pkg::ST_LEN: begin
					buf_q  <= {buf_q[503:0], bits_q[63:56]};
					bits_q <= {bits_q[55:0], 8'h00};
				end
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: verif/tb_sha256_hash_engine.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_sha256_hash_engine;

	// sent word: action plus message byte
	typedef struct packed {
		logic       action;
		logic [7:0] data_byte;
	} msg_word_t;

	// one digest word as the block should emit it
	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} digest_entry_t;

	localparam logic ACT_ABSORB = 1'b0;
	localparam logic ACT_FINISH = 1'b1;

	localparam logic [31:0] HASH_INIT [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        action;
	logic [7:0]  data_byte;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	sha256_hash_engine i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .data_byte(data_byte),
		.out_valid(out_valid), .out_stall(out_stall),
		.digest_word(digest_word), .word_index(word_index),
		.last_word(last_word)
	);

	// pending words; a word whose drain mark is set makes the driver hold
	// off until every digest word has come back
	msg_word_t     pending_words[$];
	bit            drain_marks[$];
	digest_entry_t digest_queue[$];

	// predictor state
	logic [31:0] hash_state [8];
	logic [7:0]  block_buf [64];
	logic [6:0]  fill_level;
	logic [60:0] msg_bytes;

	int  fail_count = 0;
	bit  stim_done  = 0;
	int  send_gap   = 0;
	int  recv_gap   = 0;

	function automatic logic [31:0] ror32(input logic [31:0] v, input int n);
		return (v >> n) | (v << (32 - n));
	endfunction

	// round constants
	function automatic logic [31:0] i_rk(input int i);
		logic [31:0] k [64];
		k = '{
			32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
			32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
			32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
			32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
			32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
			32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
			32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
			32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
			32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
			32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
			32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
			32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
			32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
			32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
			32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
			32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
		};
		return k[i];
	endfunction

	task automatic compress_block();
		logic [31:0] w [64];
		logic [31:0] v [8];
		logic [31:0] s0, s1, t1, t2;
		for (int i = 0; i < 16; i++)
			w[i] = {block_buf[4*i], block_buf[4*i+1], block_buf[4*i+2], block_buf[4*i+3]};
		for (int i = 16; i < 64; i++) begin
			s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
			s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
			w[i] = w[i-16] + s0 + w[i-7] + s1;
		end
		for (int i = 0; i < 8; i++)
			v[i] = hash_state[i];
		for (int i = 0; i < 64; i++) begin
			t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + i_rk(i) + w[i];
			t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			hash_state[i] = hash_state[i] + v[i];
	endtask

	task automatic hash_reset();
		for (int i = 0; i < 8; i++)
			hash_state[i] = HASH_INIT[i];
		fill_level = '0;
		msg_bytes  = '0;
	endtask

	// predict the effect of one accepted word
	task automatic hash_word(input msg_word_t wd);
		logic [63:0] bits;
		digest_entry_t de;
		if (wd.action == ACT_ABSORB) begin
			block_buf[fill_level[5:0]] = wd.data_byte;
			fill_level = fill_level + 7'd1;
			msg_bytes  = msg_bytes + 61'd1;
			if (fill_level == 7'd64) begin
				compress_block();
				fill_level = '0;
			end
		end else begin
			bits = {msg_bytes, 3'b000};
			block_buf[fill_level[5:0]] = 8'h80;
			fill_level = fill_level + 7'd1;
			if (fill_level > 7'd56) begin
				while (fill_level < 7'd64) begin
					block_buf[fill_level[5:0]] = 8'h00;
					fill_level = fill_level + 7'd1;
				end
				compress_block();
				fill_level = '0;
			end
			while (fill_level < 7'd56) begin
				block_buf[fill_level[5:0]] = 8'h00;
				fill_level = fill_level + 7'd1;
			end
			for (int i = 0; i < 8; i++)
				block_buf[63-i] = bits[8*i +: 8];
			compress_block();
			for (int i = 0; i < 8; i++) begin
				de.digest_word = hash_state[i];
				de.word_index  = 3'(i);
				de.last_word   = (i == 7);
				digest_queue.push_back(de);
			end
			hash_reset();
		end
	endtask

	// clock and reset
	initial clk = 1'b0;
	always #10 clk = ~clk;

	initial begin
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	// stimulus: directed words, then random messages
	task automatic queue_word(input logic act, input logic [7:0] b, input bit drain = 0);
		msg_word_t wd;
		wd.action = act;
		wd.data_byte = b;
		pending_words.push_back(wd);
		drain_marks.push_back(drain);
	endtask

	initial begin
		int len;
		hash_reset();
		// empty message, twice (second checks the return to initial state)
		queue_word(ACT_FINISH, 8'h00);
		queue_word(ACT_FINISH, 8'hff);
		// "abc"
		queue_word(ACT_ABSORB, 8'h61);
		queue_word(ACT_ABSORB, 8'h62);
		queue_word(ACT_ABSORB, 8'h63);
		queue_word(ACT_FINISH, 8'h5a);
		// extreme bytes, then hold off until the digest has drained
		queue_word(ACT_ABSORB, 8'h00);
		queue_word(ACT_ABSORB, 8'hff);
		queue_word(ACT_ABSORB, 8'haa);
		queue_word(ACT_ABSORB, 8'h55);
		queue_word(ACT_FINISH, 8'h00, 1);
		// random messages; lengths around the 55/56/64 padding boundaries
		// come up often, the last one fills a whole block
		for (int m = 0; m < 4; m++) begin
			case ($urandom_range(0, 3))
				0: len = $urandom_range(54, 57);
				1: len = $urandom_range(62, 65);
				2: len = $urandom_range(0, 12);
				default: len = $urandom_range(0, 20);
			endcase
			if (m == 3)
				len = 64;
			for (int i = 0; i < len; i++)
				queue_word(ACT_ABSORB, 8'($urandom));
			queue_word(ACT_FINISH, 8'($urandom), m == 1);
		end
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid  <= 1'b0;
			action    <= 1'b0;
			data_byte <= 8'h00;
			send_gap  <= $urandom_range(0, 15);
		end else begin
			if (in_valid && !in_stall) begin
				hash_word('{action, data_byte});
			end
			if (in_valid && in_stall) begin
				// hold the word
			end else if (send_gap > 0) begin
				in_valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (pending_words.size() > 0 && drain_marks[0]
					&& (digest_queue.size() > 0 || (in_valid && action == ACT_FINISH))) begin
				in_valid <= 1'b0;
			end else if (pending_words.size() > 0) begin
				in_valid  <= 1'b1;
				action    <= pending_words[0].action;
				data_byte <= pending_words[0].data_byte;
				void'(pending_words.pop_front());
				void'(drain_marks.pop_front());
				// long runs without gaps now and then
				send_gap  <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
			end else begin
				in_valid <= 1'b0;
				stim_done <= 1'b1;
			end
		end
	end

	// monitor with random receive stalls
	always @(posedge clk or negedge arst_n) begin
		digest_entry_t exp_w;
		if (!arst_n) begin
			out_stall <= 1'b0;
			recv_gap  <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (digest_queue.size() == 0) begin
					$display("%0t: unexpected digest word %h index %0d last %b",
						$time, digest_word, word_index, last_word);
					fail_count = fail_count + 1;
				end else begin
					exp_w = digest_queue.pop_front();
					if (exp_w.digest_word !== digest_word) begin
						$display("%0t: digest_word expected %h actual %h", $time,
							exp_w.digest_word, digest_word);
						fail_count = fail_count + 1;
					end
					if (exp_w.word_index !== word_index) begin
						$display("%0t: word_index expected %0d actual %0d", $time,
							exp_w.word_index, word_index);
						fail_count = fail_count + 1;
					end
					if (exp_w.last_word !== last_word) begin
						$display("%0t: last_word expected %b actual %b", $time,
							exp_w.last_word, last_word);
						fail_count = fail_count + 1;
					end
				end
			end
			if (recv_gap > 0) begin
				out_stall <= 1'b1;
				recv_gap  <= recv_gap - 1;
			end else begin
				out_stall <= 1'b0;
				recv_gap  <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 15) : 0;
			end
		end
	end

	// end of run
	initial begin
		wait (stim_done);
		while (digest_queue.size() > 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (fail_count == 0 && digest_queue.size() == 0)
			$display("sha256_hash_engine test passed");
		else
			$display("sha256_hash_engine test failed");
		$finish;
	end

	initial begin
		#20ms;
		$display("sha256_hash_engine test failed");
		$finish;
	end

endmodule
`default_nettype wire
